### hw/rtl/qcfs_pkg.sv
// ----------------------------------------------------------------------------
// qcfs_pkg
// Shared types and constants of the quarter cell flow split pipeline.
// ----------------------------------------------------------------------------
package qcfs_pkg;

    localparam int ELEV_BITS_DEF     = 24;
    localparam int ANGLE_BITS_DEF    = 16;
    localparam int FRACTION_BITS_DEF = 15;

    localparam int CORDIC_STEPS = 28;
    localparam int ACC_BITS     = 30;
    localparam int NORM_BIT     = 40;
    localparam int XY_BITS      = 45;
    localparam int Z_BITS       = 32;
    localparam int SH_BITS      = $clog2(NORM_BIT + 1);

    localparam logic [ACC_BITS-1:0] ATAN_TAB [CORDIC_STEPS] = '{
        30'd536870912, 30'd316933406, 30'd167458907, 30'd85004756, 30'd42667331,
        30'd21354465, 30'd10679838, 30'd5340245, 30'd2670163, 30'd1335087,
        30'd667544, 30'd333772, 30'd166886, 30'd83443, 30'd41722, 30'd20861,
        30'd10430, 30'd5215, 30'd2608, 30'd1304, 30'd652, 30'd326, 30'd163,
        30'd81, 30'd41, 30'd20, 30'd10, 30'd5
    };

    typedef enum logic {
        METHOD_WIDTH = 1'b0,
        METHOD_AREA  = 1'b1
    } t_method;

    typedef struct packed {
        logic       flag;
        logic [1:0] sector;
    } t_side;

endpackage

### hw/rtl/qcfs_front.sv
// ----------------------------------------------------------------------------
// qcfs_front
// Gradient pair, sector selection and in-sector components, two stages.
// ----------------------------------------------------------------------------
module qcfs_front
    import qcfs_pkg::*;
#(
    parameter int ELEV_BITS = ELEV_BITS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_en,
    input  logic                        i_vld,
    input  logic signed [ELEV_BITS-1:0] i_center_elev,
    input  logic signed [ELEV_BITS-1:0] i_first_neighbour_elev,
    input  logic signed [ELEV_BITS-1:0] i_second_neighbour_elev,
    input  logic [1:0]                  i_quarter,
    input  logic                        i_neighbours_present,
    input  t_method                     i_method,
    output logic                        o_vld,
    output t_side                       o_side,
    output t_method                     o_method,
    output logic [ELEV_BITS-1:0]        o_u,
    output logic [ELEV_BITS-1:0]        o_v
);

    logic signed [ELEV_BITS:0] r_dx, r_dy;
    logic [1:0]                r_q;
    logic                      r_pres, r_vld1;
    t_method                   r_method1;

    logic                      r_vld2;
    t_side                     r_side;
    t_method                   r_method2;
    logic [ELEV_BITS-1:0]      r_u, r_v;

    logic signed [ELEV_BITS:0] n_dx, n_dy, ndx, ndy;
    logic [1:0]                n_s0;
    logic [ELEV_BITS-1:0]      n_u, n_v;

    always_comb begin
        n_dx = $signed({i_center_elev[ELEV_BITS-1], i_center_elev})
             - $signed({i_first_neighbour_elev[ELEV_BITS-1], i_first_neighbour_elev});
        n_dy = $signed({i_center_elev[ELEV_BITS-1], i_center_elev})
             - $signed({i_second_neighbour_elev[ELEV_BITS-1], i_second_neighbour_elev});
    end

    always_comb begin
        ndx = -r_dx;
        ndy = -r_dy;
        if (r_dx > 0 && r_dy >= 0) begin
            n_s0 = 2'd0;
            n_u  = r_dx[ELEV_BITS-1:0];
            n_v  = r_dy[ELEV_BITS-1:0];
        end else if (r_dx <= 0 && r_dy > 0) begin
            n_s0 = 2'd1;
            n_u  = r_dy[ELEV_BITS-1:0];
            n_v  = ndx[ELEV_BITS-1:0];
        end else if (r_dx < 0 && r_dy <= 0) begin
            n_s0 = 2'd2;
            n_u  = ndx[ELEV_BITS-1:0];
            n_v  = ndy[ELEV_BITS-1:0];
        end else begin
            n_s0 = 2'd3;
            n_u  = ndy[ELEV_BITS-1:0];
            n_v  = r_dx[ELEV_BITS-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld1 <= 1'b0;
            r_vld2 <= 1'b0;
        end else if (i_en) begin
            r_vld1 <= i_vld;
            r_vld2 <= r_vld1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_dx          <= n_dx;
            r_dy          <= n_dy;
            r_q           <= i_quarter;
            r_pres        <= i_neighbours_present;
            r_method1     <= i_method;
            r_side.flag   <= r_pres && !(r_dx == 0 && r_dy == 0);
            r_side.sector <= n_s0 + r_q;
            r_method2     <= r_method1;
            r_u           <= n_u;
            r_v           <= n_v;
        end
    end

    assign o_vld    = r_vld2;
    assign o_side   = r_side;
    assign o_method = r_method2;
    assign o_u      = r_u;
    assign o_v      = r_v;

endmodule

### hw/rtl/qcfs_div.sv
// ----------------------------------------------------------------------------
// qcfs_div
// Split share: operand setup, one restoring division step per stage, rounding.
// ----------------------------------------------------------------------------
module qcfs_div
    import qcfs_pkg::*;
#(
    parameter int ELEV_BITS     = ELEV_BITS_DEF,
    parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_en,
    input  t_method                    i_method,
    input  logic [ELEV_BITS-1:0]       i_u,
    input  logic [ELEV_BITS-1:0]       i_v,
    output logic [FRACTION_BITS:0]     o_frac
);

    localparam int DW    = ELEV_BITS + 1;
    localparam int QB    = FRACTION_BITS + 2;
    localparam int STEPS = FRACTION_BITS + 2;

    logic [DW-1:0] r_d [STEPS+1];
    logic [DW-1:0] r_r [STEPS+1];
    logic [QB-1:0] r_q [STEPS+1];
    logic [FRACTION_BITS:0] r_frac;

    logic [DW-1:0] n_d [STEPS+1];
    logic [DW-1:0] n_r [STEPS+1];
    logic [QB-1:0] n_q [STEPS+1];
    logic [DW:0]   rem2 [STEPS];
    logic          qbit [STEPS];
    logic [QB:0]   rnd;
    logic [DW-1:0] u2, v2, uw, vw;

    always_comb begin
        uw  = DW'(i_u);
        vw  = DW'(i_v);
        u2  = uw << 1;
        v2  = vw << 1;
        if (i_method == METHOD_WIDTH) begin
            n_r[0] = uw;
            n_d[0] = uw + vw;
        end else if (i_v < i_u) begin
            n_r[0] = u2 - vw;
            n_d[0] = u2;
        end else begin
            n_r[0] = uw;
            n_d[0] = v2;
        end
        n_q[0] = '0;
        for (int k = 0; k < STEPS; k++) begin
            rem2[k] = (k == 0) ? {1'b0, r_r[k]} : {r_r[k], 1'b0};
            qbit[k] = rem2[k] >= {1'b0, r_d[k]};
            n_r[k+1] = qbit[k] ? DW'(rem2[k] - {1'b0, r_d[k]}) : DW'(rem2[k]);
            n_d[k+1] = r_d[k];
            n_q[k+1] = {r_q[k][QB-2:0], qbit[k]};
        end
        rnd = {1'b0, r_q[STEPS]} + (QB+1)'(1);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k <= STEPS; k++) begin
                r_d[k] <= n_d[k];
                r_r[k] <= n_r[k];
                r_q[k] <= n_q[k];
            end
            r_frac <= rnd[FRACTION_BITS+1:1];
        end
    end

    assign o_frac = r_frac;

endmodule

### hw/rtl/qcfs_cordic.sv
// ----------------------------------------------------------------------------
// qcfs_cordic
// In-sector angle: normalize, vectoring CORDIC one step per stage, round.
// ----------------------------------------------------------------------------
module qcfs_cordic
    import qcfs_pkg::*;
#(
    parameter int ELEV_BITS  = ELEV_BITS_DEF,
    parameter int ANGLE_BITS = ANGLE_BITS_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_en,
    input  logic                    i_vld,
    input  t_side                   i_side,
    input  logic [ELEV_BITS-1:0]    i_u,
    input  logic [ELEV_BITS-1:0]    i_v,
    output logic                    o_vld,
    output t_side                   o_side,
    output logic [ANGLE_BITS-3:0]   o_off
);

    localparam int SHR = ACC_BITS - (ANGLE_BITS - 2);
    localparam logic [Z_BITS-1:0] HALF   = Z_BITS'(1) << (SHR - 1);
    localparam logic [Z_BITS-1:0] MAXOFF = (Z_BITS'(1) << (ANGLE_BITS - 2)) - Z_BITS'(1);

    logic                 r_n_vld;
    t_side                r_n_side;
    logic [ELEV_BITS-1:0] r_n_u, r_n_v;
    logic [SH_BITS-1:0]   r_n_sh;

    logic                     r_vld  [CORDIC_STEPS+1];
    t_side                    r_side [CORDIC_STEPS+1];
    logic signed [XY_BITS-1:0] r_x   [CORDIC_STEPS+1];
    logic signed [XY_BITS-1:0] r_y   [CORDIC_STEPS+1];
    logic signed [Z_BITS-1:0]  r_z   [CORDIC_STEPS+1];

    logic                  r_o_vld;
    t_side                 r_o_side;
    logic [ANGLE_BITS-3:0] r_o_off;

    logic [ELEV_BITS-1:0]      m;
    logic [SH_BITS-1:0]        n_sh;
    logic signed [XY_BITS-1:0] n_x [CORDIC_STEPS+1];
    logic signed [XY_BITS-1:0] n_y [CORDIC_STEPS+1];
    logic signed [Z_BITS-1:0]  n_z [CORDIC_STEPS+1];
    logic signed [XY_BITS-1:0] sx, sy;
    logic signed [Z_BITS-1:0]  at;
    logic [Z_BITS-1:0]         zc, off;

    always_comb begin
        m    = (i_u > i_v) ? i_u : i_v;
        n_sh = SH_BITS'(NORM_BIT);
        for (int i = 0; i < ELEV_BITS; i++) begin
            if (m[i]) n_sh = SH_BITS'(NORM_BIT - i);
        end
    end

    always_comb begin
        n_x[0] = $signed(XY_BITS'(r_n_u) << r_n_sh);
        n_y[0] = $signed(XY_BITS'(r_n_v) << r_n_sh);
        n_z[0] = '0;
        for (int i = 0; i < CORDIC_STEPS; i++) begin
            sx = r_y[i] >>> i;
            sy = r_x[i] >>> i;
            at = $signed(Z_BITS'(ATAN_TAB[i]));
            if (!r_y[i][XY_BITS-1]) begin
                n_x[i+1] = r_x[i] + sx;
                n_y[i+1] = r_y[i] - sy;
                n_z[i+1] = r_z[i] + at;
            end else begin
                n_x[i+1] = r_x[i] - sx;
                n_y[i+1] = r_y[i] + sy;
                n_z[i+1] = r_z[i] - at;
            end
        end
        zc  = r_z[CORDIC_STEPS][Z_BITS-1] ? '0 : $unsigned(r_z[CORDIC_STEPS]);
        off = (zc + HALF) >> SHR;
        if (off > MAXOFF) off = MAXOFF;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_n_vld <= 1'b0;
            for (int i = 0; i <= CORDIC_STEPS; i++) r_vld[i] <= 1'b0;
            r_o_vld <= 1'b0;
        end else if (i_en) begin
            r_n_vld  <= i_vld;
            r_vld[0] <= r_n_vld;
            for (int i = 0; i < CORDIC_STEPS; i++) r_vld[i+1] <= r_vld[i];
            r_o_vld  <= r_vld[CORDIC_STEPS];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_n_side  <= i_side;
            r_n_u     <= i_u;
            r_n_v     <= i_v;
            r_n_sh    <= n_sh;
            r_side[0] <= r_n_side;
            for (int i = 0; i <= CORDIC_STEPS; i++) begin
                r_x[i] <= n_x[i];
                r_y[i] <= n_y[i];
                r_z[i] <= n_z[i];
            end
            for (int i = 0; i < CORDIC_STEPS; i++) r_side[i+1] <= r_side[i];
            r_o_side <= r_side[CORDIC_STEPS];
            r_o_off  <= off[ANGLE_BITS-3:0];
        end
    end

    assign o_vld  = r_o_vld;
    assign o_side = r_o_side;
    assign o_off  = r_o_off;

endmodule

### hw/rtl/quarter_cell_flow_split.sv
// Throughput: one item per cycle unless stalled.
// The 28-step CORDIC pipeline sets the depth.
// A stall on the result side holds every stage at once; no item is lost.
// Reset: sync, active low; zeroes split_method and valid bits except valid_res.
// ----------------------------------------------------------------------------
// quarter_cell_flow_split
// Flow aspect, sector and split share for one quarter of a grid cell.
// ----------------------------------------------------------------------------
module quarter_cell_flow_split
    import qcfs_pkg::*;
#(
    parameter int ELEV_BITS     = ELEV_BITS_DEF,
    parameter int ANGLE_BITS    = ANGLE_BITS_DEF,
    parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_split_method_we,
    input  logic                        i_split_method,
    input  logic                        i_valid,
    output logic                        o_stall,
    input  logic signed [ELEV_BITS-1:0] i_center_elev,
    input  logic signed [ELEV_BITS-1:0] i_first_neighbour_elev,
    input  logic signed [ELEV_BITS-1:0] i_second_neighbour_elev,
    input  logic [1:0]                  i_quarter,
    input  logic                        i_neighbours_present,
    output logic                        o_valid,
    input  logic                        i_stall,
    output logic                        o_valid_res,
    output logic [1:0]                  o_flow_sector,
    output logic [FRACTION_BITS:0]      o_split_fraction,
    output logic [ANGLE_BITS-1:0]       o_aspect
);

    localparam int DIV_LAT = FRACTION_BITS + 4;
    localparam int COR_LAT = CORDIC_STEPS + 3;
    localparam int PAD     = COR_LAT - DIV_LAT;

    t_method r_method;
    logic    en;

    logic                 f_vld;
    t_side                f_side;
    t_method              f_method;
    logic [ELEV_BITS-1:0] f_u, f_v;

    logic [FRACTION_BITS:0] d_frac;
    logic [FRACTION_BITS:0] r_pad [PAD];

    logic                  c_vld;
    t_side                 c_side;
    logic [ANGLE_BITS-3:0] c_off;

    logic                   r_o_valid, r_o_res;
    logic [1:0]             r_o_sector;
    logic [FRACTION_BITS:0] r_o_frac;
    logic [ANGLE_BITS-1:0]  r_o_aspect;

    assign en      = !r_o_valid || !i_stall;
    assign o_stall = !en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_method <= METHOD_WIDTH;
        end else if (i_split_method_we) begin
            r_method <= t_method'(i_split_method);
        end
    end

    qcfs_front #(.ELEV_BITS(ELEV_BITS)) u_front (
        .i_clk                   (i_clk),
        .i_rst_n                 (i_rst_n),
        .i_en                    (en),
        .i_vld                   (i_valid),
        .i_center_elev           (i_center_elev),
        .i_first_neighbour_elev  (i_first_neighbour_elev),
        .i_second_neighbour_elev (i_second_neighbour_elev),
        .i_quarter               (i_quarter),
        .i_neighbours_present    (i_neighbours_present),
        .i_method                (r_method),
        .o_vld                   (f_vld),
        .o_side                  (f_side),
        .o_method                (f_method),
        .o_u                     (f_u),
        .o_v                     (f_v)
    );

    qcfs_div #(.ELEV_BITS(ELEV_BITS), .FRACTION_BITS(FRACTION_BITS)) u_div (
        .i_clk    (i_clk),
        .i_en     (en),
        .i_method (f_method),
        .i_u      (f_u),
        .i_v      (f_v),
        .o_frac   (d_frac)
    );

    qcfs_cordic #(.ELEV_BITS(ELEV_BITS), .ANGLE_BITS(ANGLE_BITS)) u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_vld   (f_vld),
        .i_side  (f_side),
        .i_u     (f_u),
        .i_v     (f_v),
        .o_vld   (c_vld),
        .o_side  (c_side),
        .o_off   (c_off)
    );

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_pad[0] <= d_frac;
            for (int i = 1; i < PAD; i++) r_pad[i] <= r_pad[i-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (en) begin
            r_o_valid <= c_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_o_res    <= c_side.flag;
            r_o_sector <= c_side.flag ? c_side.sector : 2'd0;
            r_o_frac   <= c_side.flag ? r_pad[PAD-1] : '0;
            r_o_aspect <= c_side.flag ? {c_side.sector, c_off} : '0;
        end
    end

    assign o_valid          = r_o_valid;
    assign o_valid_res      = r_o_res;
    assign o_flow_sector    = r_o_sector;
    assign o_split_fraction = r_o_frac;
    assign o_aspect         = r_o_aspect;

`ifndef SYNTHESIS
    a_sector_in_aspect: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_valid_res |-> o_aspect[ANGLE_BITS-1:ANGLE_BITS-2] == o_flow_sector)
        else $error("aspect top bits differ from sector");
    a_invalid_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_valid_res |-> o_aspect == '0 && o_split_fraction == '0
            && o_flow_sector == 2'd0)
        else $error("invalid result carries nonzero fields");
    a_frac_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_valid_res |-> o_split_fraction <= ((FRACTION_BITS+1)'(1) << FRACTION_BITS))
        else $error("split fraction above one");
    a_held_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |=> $stable(r_pad[PAD-1]))
        else $error("share pipeline moved during stall");
`endif

endmodule
